// File: rtl/sorted_multiset_counter_unit_macros.svh
// Assertion macros for the sorted multiset counter unit.
// Has no dependencies. The top level includes it.
`ifndef SORTED_MULTISET_COUNTER_UNIT_MACROS_SVH
`define SORTED_MULTISET_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTH
// Implication or plain property, checked on every rising edge outside reset.
`define SMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// A condition that must never be true outside reset.
`define SMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SMC_ASSERT(lbl, clk, rstn, prop, msg)
`define SMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: rtl/smc_pkg.sv
// Shared types and constants for the sorted multiset counter unit.
// Has no dependencies; used by smc_cell and the top level.
package smc_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 32;
  localparam int unsigned DistW  = 7;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic                     incr;   // add one to the matching entry
    logic                     ins;    // open a slot and place the value
    logic signed [ValueW-1:0] value;  // value under test
  } cell_ctrl_t;

endpackage

// File: rtl/sorted_multiset_counter_unit.sv
// Top level of the sorted multiset counter unit: beat registers, control and the cell row.
// Depends on smc_pkg, smc_cell and sorted_multiset_counter_unit_macros.svh.
//
// The unit keeps up to TABLE_DEPTH distinct signed 32-bit values in ascending order, each
// with a 16-bit count. A beat on the input stream carries a kind in tuser (insert, query,
// clear; the unused code acts as a query) and the value in tdata. Every beat gives exactly
// one result beat with the value's count after the operation, the saturating total of all
// counts, the number of distinct entries and a flag that an insert of a new value was
// dropped because the table was full. The table is a row of cells; each cell compares its
// entry with the value in parallel, so a match is found, a count bumped, or a new value
// slotted in with every entry above it moved up one cell, all in the same cycle. An input
// beat is registered in the operation register, worked on by the cell row once the output
// register can take its result, and its result then lands in the output register. One beat
// per cycle is sustained while the output side keeps taking results. The path that sets the
// clock is the value compare in every cell followed by the match reduction over the row.
// There is no clearing pass: an entry counts as valid only below the fill count, and a
// clear simply zeroes that count.
module sorted_multiset_counter_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [15:0] count_of_value, [47:16] total_items,
                                      // [54:48] distinct_entries, [55] dropped
);

  `include "sorted_multiset_counter_unit_macros.svh"

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  // Operation register between the input beat and the cell row.
  logic                              op_vld_q, op_vld_d;
  smc_pkg::kind_e                    op_kind_q;
  logic signed [smc_pkg::ValueW-1:0] op_value_q;

  // Table bookkeeping.
  logic [CntW-1:0]            used_q, used_d;
  logic [smc_pkg::TotalW-1:0] total_q, total_d;

  // Output register.
  logic                       m_vld_q, m_vld_d;
  logic [smc_pkg::CountW-1:0] res_count_q, res_count_d;
  logic [smc_pkg::TotalW-1:0] res_total_q;
  logic [CntW-1:0]            res_used_q;
  logic                       res_drop_q, res_drop_d;

  logic in_fire;
  logic exec;

  assign exec          = op_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = !op_vld_q || exec;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    op_vld_d = op_vld_q;
    if (in_fire) begin
      op_vld_d = 1'b1;
    end else if (exec) begin
      op_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
    end else begin
      op_vld_q <= op_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_kind_q  <= smc_pkg::kind_e'(s_axis_tuser);
      op_value_q <= s_axis_tdata;
    end
  end

  // Cell row.
  smc_pkg::cell_ctrl_t               ctrl;
  logic signed [smc_pkg::ValueW-1:0] cell_value [TABLE_DEPTH];
  logic [smc_pkg::CountW-1:0]        cell_count [TABLE_DEPTH];
  logic [smc_pkg::CountW-1:0]        hit_part   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]            cell_lt;
  logic [TABLE_DEPTH-1:0]            cell_eq;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                              left_lt;
    logic signed [smc_pkg::ValueW-1:0] left_value;
    logic [smc_pkg::CountW-1:0]        left_count;

    if (i == 0) begin : g_head
      // The head cell has nothing to its left, so it acts as if its left neighbour were below the value.
      assign left_lt    = 1'b1;
      assign left_value = op_value_q;
      assign left_count = smc_pkg::CountW'(1);
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
      assign left_count = cell_count[i-1];
    end

    smc_cell u_cell (
      .clk_i        (clk_i),
      .en_i         (exec),
      .ctrl_i       (ctrl),
      .valid_i      (CntW'(i) < used_q),
      .left_lt_i    (left_lt),
      .left_value_i (left_value),
      .left_count_i (left_count),
      .value_o      (cell_value[i]),
      .count_o      (cell_count[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );

    assign hit_part[i] = cell_eq[i] ? cell_count[i] : '0;
  end

  // At most one cell matches, so an OR over the masked counts selects its count.
  logic [smc_pkg::CountW-1:0] hit_count;
  always_comb begin
    hit_count = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      hit_count = hit_count | hit_part[k];
    end
  end

  logic found, full, is_insert, is_clear, ins_new, cnt_ok, tot_inc, drop_now;

  assign found     = |cell_eq;
  assign full      = (used_q == DepthCnt);
  assign is_insert = (op_kind_q == smc_pkg::KIND_INSERT);
  assign is_clear  = (op_kind_q == smc_pkg::KIND_CLEAR);
  assign ins_new   = is_insert && !found && !full;
  assign drop_now  = is_insert && !found && full;
  assign cnt_ok    = (hit_count != smc_pkg::CountMax);
  assign tot_inc   = (is_insert && found && cnt_ok) || ins_new;

  always_comb begin
    ctrl.incr  = is_insert && found;
    ctrl.ins   = ins_new;
    ctrl.value = op_value_q;
  end

  always_comb begin
    used_d  = used_q;
    total_d = total_q;
    if (is_clear) begin
      used_d  = '0;
      total_d = '0;
    end else begin
      if (ins_new) begin
        used_d = used_q + CntW'(1);
      end
      if (tot_inc && (total_q != smc_pkg::TotalMax)) begin
        total_d = total_q + smc_pkg::TotalW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      total_q <= '0;
    end else if (exec) begin
      used_q  <= used_d;
      total_q <= total_d;
    end
  end

  // Result of the operation in flight.
  always_comb begin
    res_drop_d = drop_now;
    unique case (op_kind_q)
      smc_pkg::KIND_INSERT: begin
        if (found) begin
          res_count_d = cnt_ok ? hit_count + smc_pkg::CountW'(1) : hit_count;
        end else begin
          res_count_d = ins_new ? smc_pkg::CountW'(1) : '0;
        end
      end
      smc_pkg::KIND_CLEAR: res_count_d = '0;
      default:             res_count_d = hit_count;
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (exec) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_count_q <= res_count_d;
      res_total_q <= total_d;
      res_used_q  <= used_d;
      res_drop_q  <= res_drop_d;
    end
  end

  // The distinct count is reported in its low seven bits.
  logic [31:0] used_ext;
  assign used_ext = 32'(res_used_q);

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {res_drop_q, used_ext[smc_pkg::DistW-1:0], res_total_q, res_count_q};

  // The fill count never runs past the number of cells.
  `SMC_ASSERT_NEVER(a_used_bound, clk_i, rst_ni, used_q > DepthCnt,
                    "fill count exceeds table depth")
  // Input backpressure only comes from a pending operation behind a stalled result.
  `SMC_ASSERT(a_ready_cause, clk_i, rst_ni,
              !s_axis_tready |-> (op_vld_q && m_vld_q && !m_axis_tready),
              "input stalled without a blocked result")
  // A clear leaves the table and the total empty.
  `SMC_ASSERT(a_clear_empties, clk_i, rst_ni,
              (exec && is_clear) |=> (used_q == '0 && total_q == '0),
              "clear did not empty the table")
  // A dropped insert leaves the fill count where it was.
  `SMC_ASSERT(a_drop_keeps, clk_i, rst_ni,
              (exec && drop_now) |=> (used_q == DepthCnt),
              "dropped insert changed the fill count")

endmodule

// File: rtl/smc_cell.sv
// One entry of the sorted table: value, count and the compare against the broadcast value.
// Depends on smc_pkg.
module smc_cell (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  smc_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             valid_i,
  input  logic                             left_lt_i,
  input  logic signed [smc_pkg::ValueW-1:0] left_value_i,
  input  logic [smc_pkg::CountW-1:0]       left_count_i,
  output logic signed [smc_pkg::ValueW-1:0] value_o,
  output logic [smc_pkg::CountW-1:0]       count_o,
  output logic                             lt_o,
  output logic                             eq_o
);

  logic signed [smc_pkg::ValueW-1:0] value_q, value_d;
  logic [smc_pkg::CountW-1:0]        count_q, count_d;

  assign lt_o = valid_i && (value_q < ctrl_i.value);
  assign eq_o = valid_i && (value_q == ctrl_i.value);

  always_comb begin
    value_d = value_q;
    count_d = count_q;
    if (ctrl_i.incr && eq_o) begin
      if (count_q != smc_pkg::CountMax) begin
        count_d = count_q + smc_pkg::CountW'(1);
      end
    end else if (ctrl_i.ins && !lt_o) begin
      // The first entry not below the value takes it; those above move up by one.
      if (left_lt_i) begin
        value_d = ctrl_i.value;
        count_d = smc_pkg::CountW'(1);
      end else begin
        value_d = left_value_i;
        count_d = left_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      count_q <= count_d;
    end
  end

  assign value_o = value_q;
  assign count_o = count_q;

endmodule

// File: tb/smc_result_checker.sv
`timescale 1ns / 1ps
// Passive checker for sorted_multiset_counter_unit: tracks its own copy of the table and compares
// every result beat with the expected one. Depends on smc_pkg.
module smc_result_checker #(
  parameter int unsigned TableDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,    // [31:0] value (signed)
  input  logic [1:0]  in_kind_i,    // [1:0] kind
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [55:0] out_data_i,   // [15:0] count, [47:16] total, [54:48] distinct, [55] dropped
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          drops_o,
  output int          saturated_o
);

  // Same layout as the result tdata, first member in the top bits.
  typedef struct packed {
    logic                       dropped;
    logic [smc_pkg::DistW-1:0]  distinct;
    logic [smc_pkg::TotalW-1:0] total;
    logic [smc_pkg::CountW-1:0] count;
  } tally_t;

  logic signed [smc_pkg::ValueW-1:0] tbl_value [TableDepth];
  logic [smc_pkg::CountW-1:0]        tbl_count [TableDepth];
  int unsigned                       tbl_used;
  logic [smc_pkg::TotalW-1:0]        tbl_total;

  tally_t tally_q[$];
  tally_t got;
  tally_t want;
  int     fail_count;
  int     results;
  int     drops;
  int     saturated;

  // Applies one beat to the local table and returns the result it should give.
  function automatic tally_t apply_beat(input logic [1:0] kind, input logic signed [31:0] v);
    int unsigned pos;
    int unsigned i;
    logic        hit;
    tally_t      r;
    pos = 0;
    while (pos < tbl_used && tbl_value[pos] < v) pos++;
    hit = (pos < tbl_used) && (tbl_value[pos] == v);
    r = '0;
    case (smc_pkg::kind_e'(kind))
      smc_pkg::KIND_INSERT: begin
        if (hit) begin
          if (tbl_count[pos] != smc_pkg::CountMax) begin
            tbl_count[pos] = tbl_count[pos] + smc_pkg::CountW'(1);
            if (tbl_total != smc_pkg::TotalMax) tbl_total = tbl_total + smc_pkg::TotalW'(1);
          end
          r.count = tbl_count[pos];
        end else if (tbl_used >= TableDepth) begin
          r.dropped = 1'b1;
        end else begin
          for (i = tbl_used; i > pos; i--) begin
            tbl_value[i] = tbl_value[i-1];
            tbl_count[i] = tbl_count[i-1];
          end
          tbl_value[pos] = v;
          tbl_count[pos] = smc_pkg::CountW'(1);
          tbl_used++;
          if (tbl_total != smc_pkg::TotalMax) tbl_total = tbl_total + smc_pkg::TotalW'(1);
          r.count = smc_pkg::CountW'(1);
        end
      end
      smc_pkg::KIND_CLEAR: begin
        tbl_used  = 0;
        tbl_total = '0;
      end
      default: begin
        if (hit) r.count = tbl_count[pos];
      end
    endcase
    r.total    = tbl_total;
    r.distinct = tbl_used[smc_pkg::DistW-1:0];
    return r;
  endfunction

  // Printing stops after a hundred lines so a broken build cannot flood the log.
  task automatic report_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned wanted);
    fail_count++;
    if (fail_count <= 100)
      $display("%0t ns: result %0d, %s is %0d, expected %0d", $time, results, what, seen, wanted);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_used  = 0;
      tbl_total = '0;
      tally_q.delete();
    end else begin
      // Results first, so a beat accepted at this edge cannot answer a result at the same edge.
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (tally_q.size() == 0) begin
          report_mismatch("unexpected result beat, tdata", out_data_i, 0);
        end else begin
          want = tally_q.pop_front();
          if (got.count != want.count) report_mismatch("count_of_value", got.count, want.count);
          if (got.total != want.total) report_mismatch("total_items", got.total, want.total);
          if (got.distinct != want.distinct)
            report_mismatch("distinct_entries", got.distinct, want.distinct);
          if (got.dropped != want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
        end
        results++;
        if (got.dropped) drops++;
        if (got.count == smc_pkg::CountMax) saturated++;
      end
      if (in_valid_i && in_ready_i) tally_q.push_back(apply_beat(in_kind_i, in_data_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= tally_q.size();
    results_o    <= results;
    drops_o      <= drops;
    saturated_o  <= saturated;
  end

endmodule

// File: tb/tb_sorted_multiset_counter_unit.sv
`timescale 1ns / 1ps
// Testbench top for sorted_multiset_counter_unit: clock, reset, stimulus and the final verdict.
// Depends on smc_pkg, the unit itself and smc_result_checker.
module tb_sorted_multiset_counter_unit;

  localparam int unsigned TableDepth  = 64;
  localparam int unsigned RandomBeats = 960;
  // The last stretch of random beats runs with both sides always ready.
  localparam int unsigned CalmBeats   = 150;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = smc_pkg::KIND_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  // When low, neither the sender nor the receiver inserts idle cycles.
  logic        idle_en = 1'b1;

  int          fail_count;
  int          pending;
  int          results;
  int          drops;
  int          saturated;
  int unsigned beats_sent;

  logic [31:0] value_pool [128];
  int unsigned pool_size;
  int unsigned episode_len;
  int unsigned random_done;
  int unsigned pick;
  int unsigned j;
  logic [31:0] v;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_multiset_counter_unit #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  smc_result_checker #(
    .TableDepth(TableDepth)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .drops_o     (drops),
    .saturated_o (saturated)
  );

  // Presents one beat and holds it until the unit takes it. Returns in the time step of the
  // accepting edge, so the next call can replace the data without dropping tvalid.
  task automatic send_beat(input smc_pkg::kind_e kind, input logic [31:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Stops sending and waits until every result already owed has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random value that often lands on a boundary or near zero, so repeats are likely.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      1:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      2, 3:    return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: takes results every cycle, except for random stalls while idling is on.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(64'd20_000_000);
    $display("tb_sorted_multiset_counter_unit failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats: empty table, both value extremes, hits and misses, the spare kind
    // and clears with the table in use.
    send_beat(smc_pkg::KIND_QUERY,  32'h0000_0000);
    send_beat(smc_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_beat(smc_pkg::KIND_INSERT, 32'h8000_0000);
    send_beat(smc_pkg::KIND_INSERT, 32'h0000_0000);
    send_beat(smc_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_beat(smc_pkg::KIND_INSERT, 32'h0000_0001);
    send_beat(smc_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_beat(smc_pkg::KIND_INSERT, 32'h8000_0000);
    send_beat(smc_pkg::KIND_QUERY,  32'hFFFF_FFFF);
    send_beat(smc_pkg::KIND_QUERY,  32'h7FFF_FFFE);
    send_beat(smc_pkg::KIND_SPARE,  32'h8000_0000);
    send_beat(smc_pkg::KIND_SPARE,  32'h0000_3039);
    send_beat(smc_pkg::KIND_CLEAR,  32'hFFFF_FFFF);
    send_beat(smc_pkg::KIND_QUERY,  32'h7FFF_FFFF);
    send_beat(smc_pkg::KIND_INSERT, 32'h5555_5555);
    send_beat(smc_pkg::KIND_INSERT, 32'hAAAA_AAAA);
    send_beat(smc_pkg::KIND_INSERT, 32'h5555_5555);
    send_beat(smc_pkg::KIND_CLEAR,  32'h0000_0000);
    wait_drained();

    // Fill the table: negatives land at the front, positives at the back. Then a new value
    // must be dropped while a value already present still counts up.
    for (j = 0; j < TableDepth; j++) begin
      v = j * 32'h0100_0101;
      send_beat(smc_pkg::KIND_INSERT, j[0] ? -v : v);
    end
    send_beat(smc_pkg::KIND_INSERT, 32'h0000_0007);
    send_beat(smc_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_beat(smc_pkg::KIND_INSERT, 32'h0200_0202);
    send_beat(smc_pkg::KIND_QUERY,  32'h0000_0007);
    send_beat(smc_pkg::KIND_SPARE,  32'h0200_0202);
    send_beat(smc_pkg::KIND_CLEAR,  32'h1234_5678);
    wait_drained();

    // Random episodes: each starts with a clear and draws most values from a pool, whose size
    // decides whether the table stays sparse or fills up and starts dropping.
    random_done = 0;
    while (random_done < RandomBeats) begin
      case ($urandom_range(0, 3))
        0:       pool_size = 6;
        1:       pool_size = 32;
        2:       pool_size = 70;
        default: pool_size = 110;
      endcase
      for (j = 0; j < pool_size; j++) value_pool[j] = pick_value();
      episode_len = $urandom_range(40, 260);
      if ($urandom_range(0, 1) == 0) wait_drained();
      send_beat(smc_pkg::KIND_CLEAR, $urandom);
      random_done++;
      for (j = 0; j < episode_len && random_done < RandomBeats; j++) begin
        if (RandomBeats - random_done <= CalmBeats) idle_en <= 1'b0;
        v    = value_pool[$urandom_range(0, pool_size - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 62)      send_beat(smc_pkg::KIND_INSERT, v);
        else if (pick < 85) send_beat(smc_pkg::KIND_QUERY, v);
        else if (pick < 90) send_beat(smc_pkg::KIND_INSERT, $urandom);
        else if (pick < 94) send_beat(smc_pkg::KIND_QUERY, $urandom);
        else if (pick < 98) send_beat(smc_pkg::KIND_SPARE, v);
        else                send_beat(smc_pkg::KIND_SPARE, $urandom);
        random_done++;
      end
    end

    // Drain, then keep the clock running so that any stray result beat can still show up.
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d beats over directed, table-fill and random phases; %0d results",
             beats_sent, results);
    $display("were checked, %0d of them dropped inserts and %0d with a saturated count.",
             drops, saturated);
    if (fail_count == 0) begin
      $display("tb_sorted_multiset_counter_unit passed");
    end else begin
      $display("tb_sorted_multiset_counter_unit failed");
    end
    $finish;
  end

endmodule
